@@ hdl/page_bitmap_allocator_unit_assert.svh @@
// Assertion macros for the page bitmap allocator.
// PBA_ASSERT_IMP: consequent checked in the same cycle as the antecedent.
// PBA_ASSERT_NXT: consequent checked in the cycle after the antecedent.
`ifndef PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define PBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pba assertion failed");
`define PBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pba assertion failed");
`else
`define PBA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PBA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/pba_pkg.sv @@
package pba_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_NO_MEM  = 2'd1,
    STS_IGNORED = 2'd2
  } status_t;

  localparam int CFG_DATA_W = 17;

  localparam logic [0:0] CFG_MANAGED  = 1'b0;
  localparam logic [0:0] CFG_RESERVED = 1'b1;

  localparam logic [CFG_DATA_W-1:0] RESERVED_RESET = 17'd1024;

endpackage

@@ hdl/pba_ram.sv @@
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/page_bitmap_allocator_unit.sv @@
// Alloc passes through S_ALLOC_SUM and S_ALLOC_MAP (answered straight from idle when no page
// is free), free through S_FREE (from idle when the page is out of range), an unused
// opcode from idle, and init through S_INIT (the sweep writes one map word a cycle).
// One item at a time: busy is high while it is in flight and the next item can be taken at
// the edge that takes the result. Results cannot be stalled.
// Reset: counts cleared, no page managed; the map RAM is not cleared and is rebuilt by init.
module page_bitmap_allocator_unit #(
  parameter int MAX_PAGES     = 65536,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_page_index,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_granted_page,
  output logic [16:0] out_free_pages,
  output logic [16:0] out_page_count,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [pba_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int W         = MAP_WORD_BITS;
  localparam int MAP_WORDS = (MAX_PAGES + W - 1) / W;
  localparam int SUM_WORDS = (MAP_WORDS + W - 1) / W;
  localparam int PAGE_W    = $clog2(MAX_PAGES);
  localparam int CNT_W     = $clog2(MAX_PAGES + 1);
  localparam int MAP_A_W   = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
  localparam int SA_W      = SUM_WORDS > 1 ? $clog2(SUM_WORDS) : 1;
  localparam int JB_W      = $clog2(W);
  localparam int SW_W      = $clog2(SUM_WORDS * W + 1);
  localparam int BASE_W    = $clog2(SUM_WORDS * W * W + 1);
  // exact division by reciprocal for page -> word and page -> summary word
  localparam int DIV_SH    = PAGE_W + 2 * JB_W;
  localparam int PROD_W    = PAGE_W + DIV_SH;
  localparam longint unsigned RECIP1 = ((64'd1 << DIV_SH) + W - 1) / W;
  localparam longint unsigned RECIP2 = ((64'd1 << DIV_SH) + W * W - 1) / (W * W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_SUM,
    S_ALLOC_MAP,
    S_FREE,
    S_INIT
  } state_t;

  state_t state_r, state_nxt;

  logic [pba_pkg::CFG_DATA_W-1:0] managed_r, managed_nxt;
  logic [pba_pkg::CFG_DATA_W-1:0] reserved_r, reserved_nxt;
  logic [CNT_W-1:0]   active_r, active_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [CNT_W-1:0]   ff_r, ff_nxt;
  logic [SUM_WORDS-1:0] top_r, top_nxt;
  logic [MAP_A_W-1:0] w_r, w_nxt;
  logic [SA_W-1:0]    s_r, s_nxt;
  logic [JB_W-1:0]    j_r, j_nxt;
  logic [PAGE_W-1:0]  idx_r, idx_nxt;
  logic [SW_W-1:0]    sw_r, sw_nxt;
  logic [BASE_W-1:0]  base_r, base_nxt;
  logic [SA_W-1:0]    grp_r, grp_nxt;
  logic [JB_W-1:0]    gbit_r, gbit_nxt;
  logic [W-1:0]       acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  pba_pkg::status_t   out_status_r, out_status_nxt;
  logic [PAGE_W-1:0]  out_granted_r, out_granted_nxt;

  logic               map_we, map_re, sum_we, sum_re;
  logic [MAP_A_W-1:0] map_waddr, map_raddr;
  logic [SA_W-1:0]    sum_waddr, sum_raddr;
  logic [W-1:0]       map_wdata, map_rdata, sum_wdata, sum_rdata;

  logic [PAGE_W-1:0]  idx_in;
  logic [PROD_W-1:0]  prod1, prod2;
  logic [MAP_A_W-1:0] q1;
  logic [SA_W-1:0]    q2;
  logic [SA_W-1:0]    s_pick;
  logic [JB_W-1:0]    j_pick, b_pick, fb, fj;
  logic [W-1:0]       free_mask, acc_cur, map_new, sum_new;
  logic [31:0]        act_sat;
  logic [CNT_W-1:0]   act_init;

  pba_ram #(.WIDTH(W), .DEPTH(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // one bit per map word: set while that word holds a free page
  pba_ram #(.WIDTH(W), .DEPTH(SUM_WORDS)) u_sum (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .re    (sum_re),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  // lowest summary word with a non-full map word
  always_comb begin
    s_pick = '0;
    for (int i = SUM_WORDS - 1; i >= 0; i--) begin
      if (top_r[i]) s_pick = SA_W'(i);
    end
  end

  always_comb begin
    j_pick = '0;
    b_pick = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (sum_rdata[i]) j_pick = JB_W'(i);
      if (!map_rdata[i]) b_pick = JB_W'(i);
    end
  end

  always_comb begin
    for (int k = 0; k < W; k++) begin
      free_mask[k] = ((base_r + BASE_W'(k)) >= BASE_W'(ff_r)) &&
                     ((base_r + BASE_W'(k)) < BASE_W'(active_r));
    end
  end

  assign idx_in  = PAGE_W'(in_page_index);
  assign prod1   = PROD_W'(idx_in) * PROD_W'(RECIP1);
  assign prod2   = PROD_W'(idx_in) * PROD_W'(RECIP2);
  assign q1      = MAP_A_W'(prod1 >> DIV_SH);
  assign q2      = SA_W'(prod2 >> DIV_SH);
  assign fb      = JB_W'(32'(idx_r) - 32'(w_r) * W);
  assign fj      = JB_W'(32'(w_r) - 32'(s_r) * W);
  assign acc_cur = acc_r | (W'(|free_mask) << gbit_r);
  assign act_sat = (32'(managed_r) > MAX_PAGES) ? 32'(MAX_PAGES) : 32'(managed_r);
  assign act_init = CNT_W'(act_sat);

  always_comb begin
    state_nxt       = state_r;
    managed_nxt     = managed_r;
    reserved_nxt    = reserved_r;
    active_nxt      = active_r;
    used_nxt        = used_r;
    ff_nxt          = ff_r;
    top_nxt         = top_r;
    w_nxt           = w_r;
    s_nxt           = s_r;
    j_nxt           = j_r;
    idx_nxt         = idx_r;
    sw_nxt          = sw_r;
    base_nxt        = base_r;
    grp_nxt         = grp_r;
    gbit_nxt        = gbit_r;
    acc_nxt         = acc_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    map_we    = 1'b0;
    map_waddr = '0;
    map_wdata = '0;
    map_re    = 1'b0;
    map_raddr = '0;
    sum_we    = 1'b0;
    sum_waddr = '0;
    sum_wdata = '0;
    sum_re    = 1'b0;
    sum_raddr = '0;
    map_new   = map_rdata | (W'(1) << b_pick);
    sum_new   = sum_rdata & ~(W'(1) << j_r);

    if (cfg_we) begin
      unique case (cfg_index)
        pba_pkg::CFG_MANAGED:  managed_nxt  = cfg_data;
        pba_pkg::CFG_RESERVED: reserved_nxt = cfg_data;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_granted_nxt = '0;
          unique case (in_opcode)
            pba_pkg::OP_ALLOC: begin
              if (used_r == active_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = pba_pkg::STS_NO_MEM;
              end else begin
                sum_re    = 1'b1;
                sum_raddr = s_pick;
                s_nxt     = s_pick;
                state_nxt = S_ALLOC_SUM;
              end
            end
            pba_pkg::OP_FREE: begin
              if (32'(in_page_index) < 32'(active_r)) begin
                map_re    = 1'b1;
                map_raddr = q1;
                sum_re    = 1'b1;
                sum_raddr = q2;
                w_nxt     = q1;
                s_nxt     = q2;
                idx_nxt   = idx_in;
                state_nxt = S_FREE;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = pba_pkg::STS_IGNORED;
              end
            end
            pba_pkg::OP_INIT: begin
              active_nxt = act_init;
              ff_nxt     = (CNT_W'(reserved_r) < act_init && 32'(reserved_r) < act_sat) ?
                           CNT_W'(reserved_r) : act_init;
              used_nxt   = ff_nxt;
              sw_nxt     = '0;
              base_nxt   = '0;
              grp_nxt    = '0;
              gbit_nxt   = '0;
              acc_nxt    = '0;
              state_nxt  = S_INIT;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = pba_pkg::STS_IGNORED;
            end
          endcase
        end
      end

      S_ALLOC_SUM: begin
        w_nxt     = MAP_A_W'(32'(s_r) * W + 32'(j_pick));
        j_nxt     = j_pick;
        map_re    = 1'b1;
        map_raddr = w_nxt;
        state_nxt = S_ALLOC_MAP;
      end

      S_ALLOC_MAP: begin
        map_we          = 1'b1;
        map_waddr       = w_r;
        map_wdata       = map_new;
        used_nxt        = used_r + CNT_W'(1);
        out_valid_nxt   = 1'b1;
        out_status_nxt  = pba_pkg::STS_DONE;
        out_granted_nxt = PAGE_W'(32'(w_r) * W + 32'(b_pick));
        if (&map_new) begin
          sum_we    = 1'b1;
          sum_waddr = s_r;
          sum_wdata = sum_new;
          if (sum_new == '0) top_nxt[s_r] = 1'b0;
        end
        state_nxt = S_IDLE;
      end

      S_FREE: begin
        out_valid_nxt = 1'b1;
        if (map_rdata[fb]) begin
          map_we         = 1'b1;
          map_waddr      = w_r;
          map_wdata      = map_rdata & ~(W'(1) << fb);
          sum_we         = 1'b1;
          sum_waddr      = s_r;
          sum_wdata      = sum_rdata | (W'(1) << fj);
          top_nxt[s_r]   = 1'b1;
          used_nxt       = used_r - CNT_W'(1);
          out_status_nxt = pba_pkg::STS_DONE;
        end else begin
          out_status_nxt = pba_pkg::STS_IGNORED;
        end
        state_nxt = S_IDLE;
      end

      S_INIT: begin
        // one map word per cycle; a summary word closes every W words
        if (sw_r < SW_W'(MAP_WORDS)) begin
          map_we    = 1'b1;
          map_waddr = MAP_A_W'(sw_r);
          map_wdata = ~free_mask;
        end
        sw_nxt   = sw_r + SW_W'(1);
        base_nxt = base_r + BASE_W'(W);
        if (gbit_r == JB_W'(W - 1)) begin
          sum_we         = 1'b1;
          sum_waddr      = grp_r;
          sum_wdata      = acc_cur;
          top_nxt[grp_r] = |acc_cur;
          acc_nxt        = '0;
          gbit_nxt       = '0;
          grp_nxt        = grp_r + SA_W'(1);
          if (32'(grp_r) == SUM_WORDS - 1) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pba_pkg::STS_DONE;
            state_nxt      = S_IDLE;
          end
        end else begin
          acc_nxt  = acc_cur;
          gbit_nxt = gbit_r + JB_W'(1);
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      managed_r   <= '0;
      reserved_r  <= pba_pkg::RESERVED_RESET;
      active_r    <= '0;
      used_r      <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      managed_r   <= managed_nxt;
      reserved_r  <= reserved_nxt;
      active_r    <= active_nxt;
      used_r      <= used_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ff_r          <= ff_nxt;
    w_r           <= w_nxt;
    s_r           <= s_nxt;
    j_r           <= j_nxt;
    idx_r         <= idx_nxt;
    sw_r          <= sw_nxt;
    base_r        <= base_nxt;
    grp_r         <= grp_nxt;
    gbit_r        <= gbit_nxt;
    acc_r         <= acc_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_page = 16'(out_granted_r);
  assign out_free_pages   = 17'(active_r - used_r);
  assign out_page_count   = 17'(active_r);

`include "page_bitmap_allocator_unit_assert.svh"

  `PBA_ASSERT_IMP(a_used_le_active, clk, rst_n, 1'b1, used_r <= active_r)
  `PBA_ASSERT_IMP(a_active_le_max, clk, rst_n, 1'b1, 32'(active_r) <= MAX_PAGES)
  // summary says a free page exists: the words fetched must agree
  `PBA_ASSERT_IMP(a_sum_nonzero, clk, rst_n, state_r == S_ALLOC_SUM, |sum_rdata)
  `PBA_ASSERT_IMP(a_map_not_full, clk, rst_n, state_r == S_ALLOC_MAP, !(&map_rdata))
  `PBA_ASSERT_NXT(a_accept_progress, clk, rst_n, start && !busy, busy || out_valid_r)

endmodule
